[hdl/assert_macros.svh]
// assertion helpers used by sdes_block_cipher_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off while in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle, off while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle, also checked through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sdes_pkg.sv]
// ----------------------------------------------------------------------------
// sdes_pkg
// permutations, s-boxes and round function of simplified des
// ----------------------------------------------------------------------------
package sdes_pkg;

    localparam int unsigned KeyWidth   = 10;
    localparam int unsigned BlockWidth = 8;
    localparam int unsigned SubkeyWidth = 8;

    typedef logic [KeyWidth-1:0]    t_key;
    typedef logic [BlockWidth-1:0]  t_block;
    typedef logic [SubkeyWidth-1:0] t_subkey;

    // entries indexed by {row, col}
    localparam logic [1:0] SBOX0 [16] = '{
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd0,
        2'd0, 2'd2, 2'd1, 2'd3,
        2'd3, 2'd1, 2'd3, 2'd2
    };
    localparam logic [1:0] SBOX1 [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd0,
        2'd2, 2'd1, 2'd0, 2'd3
    };

    // bit position 1 is the msb in every permutation below
    function automatic t_block perm_ip(input t_block v);
        return {v[6], v[2], v[5], v[7], v[4], v[0], v[3], v[1]};
    endfunction

    function automatic t_block perm_ip_inv(input t_block v);
        return {v[4], v[7], v[5], v[3], v[1], v[6], v[0], v[2]};
    endfunction

    function automatic t_key perm_p10(input t_key v);
        return {v[7], v[5], v[8], v[3], v[6], v[0], v[9], v[1], v[2], v[4]};
    endfunction

    function automatic t_subkey perm_p8(input t_key v);
        return {v[4], v[7], v[3], v[6], v[2], v[5], v[0], v[1]};
    endfunction

    function automatic logic [7:0] perm_ep(input logic [3:0] v);
        return {v[0], v[3], v[2], v[1], v[2], v[1], v[0], v[3]};
    endfunction

    function automatic logic [3:0] perm_p4(input logic [3:0] v);
        return {v[2], v[0], v[1], v[3]};
    endfunction

    function automatic logic [4:0] rot1(input logic [4:0] h);
        return {h[3:0], h[4]};
    endfunction

    function automatic logic [4:0] rot3(input logic [4:0] h);
        return {h[1:0], h[4:2]};
    endfunction

    function automatic t_subkey subkey1(input t_key key);
        t_key k10;
        k10 = perm_p10(key);
        return perm_p8({rot1(k10[9:5]), rot1(k10[4:0])});
    endfunction

    function automatic t_subkey subkey2(input t_key key);
        t_key k10;
        k10 = perm_p10(key);
        return perm_p8({rot3(k10[9:5]), rot3(k10[4:0])});
    endfunction

    // one feistel round: left half is xored with p4 of the s-box outputs
    function automatic t_block round_fk(input t_block x, input t_subkey k);
        logic [7:0] t;
        logic [1:0] s0;
        logic [1:0] s1;
        t  = perm_ep(x[3:0]) ^ k;
        s0 = SBOX0[{t[7], t[4], t[6:5]}];
        s1 = SBOX1[{t[3], t[0], t[2:1]}];
        return {x[7:4] ^ perm_p4({s0, s1}), x[3:0]};
    endfunction

endpackage

[hdl/sdes_keysched.sv]
// ----------------------------------------------------------------------------
// sdes_keysched
// key register, derives both subkeys once per key write
// ----------------------------------------------------------------------------
module sdes_keysched (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_key_we,
    input  sdes_pkg::t_key       i_key,
    output sdes_pkg::t_subkey    o_k1,
    output sdes_pkg::t_subkey    o_k2
);

    sdes_pkg::t_subkey r_k1;
    sdes_pkg::t_subkey r_k2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1 <= sdes_pkg::subkey1('0);
            r_k2 <= sdes_pkg::subkey2('0);
        end else if (i_key_we) begin
            r_k1 <= sdes_pkg::subkey1(i_key);
            r_k2 <= sdes_pkg::subkey2(i_key);
        end
    end

    assign o_k1 = r_k1;
    assign o_k2 = r_k2;

endmodule

[hdl/sdes_ip_stage.sv]
// ----------------------------------------------------------------------------
// sdes_ip_stage
// entry stage: initial permutation of the block
// ----------------------------------------------------------------------------
module sdes_ip_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  sdes_pkg::t_block   i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_op,
    output sdes_pkg::t_block   o_x
);

    logic             r_valid;
    logic             r_op;
    sdes_pkg::t_block r_x;
    logic             w_ready;

    assign w_ready = !r_valid || !i_stall;
    assign o_stall = !w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_op <= i_op;
            r_x  <= sdes_pkg::perm_ip(i_data);
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_x     = r_x;

endmodule

[hdl/sdes_round_stage.sv]
// ----------------------------------------------------------------------------
// sdes_round_stage
// one fk round as a pipeline stage, subkey picked by operation and round
// ----------------------------------------------------------------------------
module sdes_round_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_late,
    input  sdes_pkg::t_subkey   i_k1,
    input  sdes_pkg::t_subkey   i_k2,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  sdes_pkg::t_block    i_x,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_op,
    output sdes_pkg::t_block    o_x
);

    logic              r_valid;
    logic              r_op;
    sdes_pkg::t_block  r_x;
    logic              w_ready;
    sdes_pkg::t_subkey w_key;

    assign w_ready = !r_valid || !i_stall;
    assign o_stall = !w_ready;

    // encrypt: k1 then k2, decrypt: k2 then k1
    assign w_key = (i_op ^ i_late) ? i_k2 : i_k1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_op <= i_op;
            r_x  <= sdes_pkg::round_fk(i_x, w_key);
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_x     = r_x;

endmodule

[hdl/sdes_block_cipher.sv]
// ----------------------------------------------------------------------------
// sdes_block_cipher: simplified des, one 8-bit block per beat
// pipeline: three register stages, ip then round 1 then round 2
// throughput: one block per cycle while the output side does not stall
// reset: synchronous active-low, empties the pipeline and clears the key to 0
// ----------------------------------------------------------------------------
module sdes_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // key register write port
    input  logic        i_cipher_key_we,
    input  logic [9:0]  i_cipher_key,
    // input beat
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_data_in,
    // output beat
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_data_out
);

    // subkeys, stable while blocks are in flight only if the user changes the key
    // while the pipeline is idle; the block itself does not enforce this
    sdes_pkg::t_subkey w_k1;
    sdes_pkg::t_subkey w_k2;

    // stage 1 -> stage 2
    logic              w_v1;
    logic              w_op1;
    sdes_pkg::t_block  w_x1;
    logic              w_stall2;

    // stage 2 -> stage 3
    logic              w_v2;
    logic              w_op2;
    sdes_pkg::t_block  w_x2;
    sdes_pkg::t_block  w_x2_swap;
    logic              w_stall3;

    // stage 3 -> output
    sdes_pkg::t_block  w_x3;

    sdes_keysched u_keysched (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key_we (i_cipher_key_we),
        .i_key    (i_cipher_key),
        .o_k1     (w_k1),
        .o_k2     (w_k2)
    );

    // stage 1: initial permutation
    sdes_ip_stage u_ip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_op     (i_operation),
        .i_data   (i_data_in),
        .o_valid  (w_v1),
        .i_stall  (w_stall2),
        .o_op     (w_op1),
        .o_x      (w_x1)
    );

    // stage 2: first round
    sdes_round_stage u_round1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_late   (1'b0),
        .i_k1     (w_k1),
        .i_k2     (w_k2),
        .i_valid  (w_v1),
        .o_stall  (w_stall2),
        .i_op     (w_op1),
        .i_x      (w_x1),
        .o_valid  (w_v2),
        .i_stall  (w_stall3),
        .o_op     (w_op2),
        .o_x      (w_x2)
    );

    // half swap between the rounds is plain wiring
    assign w_x2_swap = {w_x2[3:0], w_x2[7:4]};

    // stage 3: second round, this register is also the output register
    sdes_round_stage u_round2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_late   (1'b1),
        .i_k1     (w_k1),
        .i_k2     (w_k2),
        .i_valid  (w_v2),
        .o_stall  (w_stall3),
        .i_op     (w_op2),
        .i_x      (w_x2_swap),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_op     (),
        .o_x      (w_x3)
    );

    // inverse ip is wiring only, so the output stays register-driven
    assign o_data_out = sdes_pkg::perm_ip_inv(w_x3);

endmodule

[hdl/sdes_block_cipher_chk.sv]
// ----------------------------------------------------------------------------
// sdes_block_cipher_chk
// port-level checks of the cipher pipeline, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdes_block_cipher_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_data_out
);

    // a held output beat keeps its data
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data_out), "output beat changed while stalled")

    // reset empties the pipeline
    `ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_valid, "output valid right after reset")

    // an empty output stage means the whole pipeline can move
    `ASSERT_SAME(a_no_stall_empty, i_clk, i_rst_n, !o_valid, !o_stall, "input stalled with empty output")

    // an accepted beat reaches the output when the output side keeps up
    `ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall, o_valid, "accepted beat did not reach the output in three cycles")

endmodule

bind sdes_block_cipher sdes_block_cipher_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_data_out (o_data_out)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sdes_block_cipher
// a short table of directed beats runs first: known-answer blocks, all-zero
// and all-one keys and blocks, both operations. random phases follow, each
// after a key write. each output beat is compared with its hand-checked answer
// or else a bit-level s-des predictor. both sides idle and stall at random, and the
// receiver once holds off long enough to back the pipeline up into the input
// ----------------------------------------------------------------------------
module tb_top;

    // operation codes on i_operation
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam int N_DIRECTED     = 16;
    localparam int RANDOM_ITEMS   = 1134;
    localparam int SETTLE_CYCLES  = 8;     // pipeline is 3 deep, a little margin
    localparam int HOLD_CYCLES    = 64;    // long receiver hold-off
    localparam int HOLD_BEATS     = 40;    // beats offered during the hold-off
    localparam int WATCHDOG_LIMIT = 1000;  // quiet cycles before giving up

    // permutation maps, entry 1 in the top nibble, bit position 1 is the msb
    localparam logic [39:0] IP_MAP  = {4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7, 8'd0};
    localparam logic [39:0] IPI_MAP = {4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6, 8'd0};
    localparam logic [39:0] P10_MAP = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd10, 4'd1, 4'd9, 4'd8,
                                       4'd6};
    localparam logic [39:0] P8_MAP  = {4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9, 8'd0};
    localparam logic [39:0] EP_MAP  = {4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1, 8'd0};
    localparam logic [39:0] P4_MAP  = {4'd2, 4'd4, 4'd3, 4'd1, 24'd0};

    // s-boxes, entry {row, col} = 0 in the top two bits
    localparam logic [31:0] S0_MAP = {2'd1, 2'd0, 2'd3, 2'd2,  2'd3, 2'd2, 2'd1, 2'd0,
                                      2'd0, 2'd2, 2'd1, 2'd3,  2'd3, 2'd1, 2'd3, 2'd2};
    localparam logic [31:0] S1_MAP = {2'd0, 2'd1, 2'd2, 2'd3,  2'd2, 2'd0, 2'd1, 2'd3,
                                      2'd3, 2'd0, 2'd1, 2'd0,  2'd2, 2'd1, 2'd0, 2'd3};

    // one row of the directed table
    typedef struct packed {
        sdes_pkg::t_key   key;
        logic             op;
        sdes_pkg::t_block data;
        logic             known;   // want holds a hand-checked answer
        sdes_pkg::t_block want;
    } t_vector;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cipher_key_we;
    logic [9:0]  i_cipher_key;
    logic        i_valid;
    logic        o_stall;
    logic        i_operation;
    logic [7:0]  i_data_in;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_data_out;

    // a hand-checked answer rides along with the beat that it belongs to
    logic              pin_known;
    sdes_pkg::t_block  pin_want;

    sdes_pkg::t_key    key_shadow;          // key the block holds right now
    sdes_pkg::t_block  pending_blocks [$];  // cipher outputs still owed, oldest first
    int                errors;
    logic              stall_on;            // receiver stalls at random
    logic              tx_idle_on;          // sender leaves gaps at random
    logic              hold_off_req;        // ask the receiver for one long hold-off
    t_vector           vec_table [N_DIRECTED];

    sdes_block_cipher dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cipher_key_we (i_cipher_key_we),
        .i_cipher_key    (i_cipher_key),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_data_in       (i_data_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_data_out      (o_data_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // s-des predictor
    // ------------------------------------------------------------------------

    // output bit j takes bit map[j] of an in_w-bit value, msb first
    function automatic logic [9:0] remap(input logic [9:0] v, input int in_w, input int out_w,
                                         input logic [39:0] map);
        logic [9:0] r;
        logic [3:0] src;
        r = '0;
        for (int j = 0; j < out_w; j++) begin
            src = map[39-4*j -: 4];
            r = {r[8:0], v[in_w - src]};
        end
        return r;
    endfunction

    function automatic logic [4:0] rotl5(input logic [4:0] h, input int n);
        return (h << n) | (h >> (5 - n));
    endfunction

    // one feistel round on an 8-bit block with an 8-bit subkey
    function automatic sdes_pkg::t_block feistel(input sdes_pkg::t_block x,
                                                 input sdes_pkg::t_subkey k);
        logic [9:0] w;
        logic [7:0] t;
        logic [3:0] i0;
        logic [3:0] i1;
        logic [3:0] s;
        w  = remap({6'd0, x[3:0]}, 4, 8, EP_MAP);
        t  = w[7:0] ^ k;
        i0 = {t[7], t[4], t[6:5]};   // row from bits 1 and 4, column from 2 and 3
        i1 = {t[3], t[0], t[2:1]};
        s  = {S0_MAP[31-2*i0 -: 2], S1_MAP[31-2*i1 -: 2]};
        w  = remap({6'd0, s}, 4, 4, P4_MAP);
        return {x[7:4] ^ w[3:0], x[3:0]};
    endfunction

    function automatic sdes_pkg::t_block sdes_predict(input sdes_pkg::t_key key, input logic op,
                                                      input sdes_pkg::t_block d);
        logic [9:0]         k10;
        logic [9:0]         w;
        sdes_pkg::t_subkey  k1;
        sdes_pkg::t_subkey  k2;
        sdes_pkg::t_block   x;
        k10 = remap(key, 10, 10, P10_MAP);
        w   = remap({rotl5(k10[9:5], 1), rotl5(k10[4:0], 1)}, 10, 8, P8_MAP);
        k1  = w[7:0];
        w   = remap({rotl5(k10[9:5], 3), rotl5(k10[4:0], 3)}, 10, 8, P8_MAP);
        k2  = w[7:0];
        w   = remap({2'd0, d}, 8, 8, IP_MAP);
        x   = feistel(w[7:0], (op == OP_DECRYPT) ? k2 : k1);
        x   = {x[3:0], x[7:4]};
        x   = feistel(x, (op == OP_DECRYPT) ? k1 : k2);
        w   = remap({2'd0, x}, 8, 8, IPI_MAP);
        return w[7:0];
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input sdes_pkg::t_block got,
                                   input sdes_pkg::t_block want);
        $display("mismatch at %0t: %s, got %02h want %02h", $time, what, got, want);
        errors++;
    endtask

    // output beats are checked before the input beat of the same edge is queued
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_blocks.size() == 0) begin
                report_mismatch("output beat with nothing pending", o_data_out, 8'h00);
            end else begin
                if (o_data_out !== pending_blocks[0])
                    report_mismatch("data_out", o_data_out, pending_blocks[0]);
                void'(pending_blocks.pop_front());
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            if (pin_known)
                pending_blocks.push_back(pin_want);
            else
                pending_blocks.push_back(sdes_predict(key_shadow, i_operation, i_data_in));
        end
    end

    // ------------------------------------------------------------------------
    // idling helpers
    // ------------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // offer one beat and hold it until it is taken
    task automatic offer_block(input logic op, input sdes_pkg::t_block data, input logic known,
                               input sdes_pkg::t_block want);
        i_valid     <= 1'b1;
        i_operation <= op;
        i_data_in   <= data;
        pin_known   <= known;
        pin_want    <= want;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic sender_gap();
        if (tx_idle_on && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    // stop sending, let every owed beat come out, then let the pipe settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only ever called with the block idle
    task automatic write_key(input sdes_pkg::t_key k);
        i_cipher_key_we <= 1'b1;
        i_cipher_key    <= k;
        @(posedge i_clk);
        i_cipher_key_we <= 1'b0;
        key_shadow       = k;
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                i_stall <= 1'b0;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat (pick_gap()) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too many cycles with no beat on either side ends the run
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sender: reset, directed table, random phases, end of run
    // ------------------------------------------------------------------------
    initial begin : sender
        int             items_left;
        int             n_beats;
        int             phase;
        sdes_pkg::t_key k;
        // every input known from time zero
        i_rst_n         <= 1'b0;
        i_cipher_key_we <= 1'b0;
        i_cipher_key    <= '0;
        i_valid         <= 1'b0;
        i_operation     <= OP_ENCRYPT;
        i_data_in       <= '0;
        pin_known       <= 1'b0;
        pin_want        <= '0;
        key_shadow   = '0;
        errors       = 0;
        stall_on     = 1'b0;
        tx_idle_on   = 1'b0;
        hold_off_req = 1'b0;

        // key, op, block, known, answer; the first rows run on the reset key
        vec_table = '{
            {10'h000, OP_ENCRYPT, 8'h00, 1'b1, 8'hF0},
            {10'h000, OP_DECRYPT, 8'hF0, 1'b1, 8'h00},
            {10'h000, OP_ENCRYPT, 8'hFF, 1'b0, 8'h00},
            {10'h000, OP_DECRYPT, 8'hFF, 1'b0, 8'h00},
            {10'h000, OP_ENCRYPT, 8'h55, 1'b0, 8'h00},
            {10'h000, OP_DECRYPT, 8'hAA, 1'b0, 8'h00},
            {10'h3FF, OP_ENCRYPT, 8'h00, 1'b0, 8'h00},
            {10'h3FF, OP_ENCRYPT, 8'hFF, 1'b0, 8'h00},
            {10'h3FF, OP_DECRYPT, 8'h00, 1'b0, 8'h00},
            {10'h3FF, OP_DECRYPT, 8'hFF, 1'b0, 8'h00},
            // textbook known-answer pair
            {10'h282, OP_ENCRYPT, 8'h97, 1'b1, 8'h38},
            {10'h282, OP_DECRYPT, 8'h38, 1'b1, 8'h97},
            {10'h2AA, OP_ENCRYPT, 8'h5A, 1'b0, 8'h00},
            {10'h2AA, OP_DECRYPT, 8'hA5, 1'b0, 8'h00},
            {10'h155, OP_ENCRYPT, 8'h81, 1'b0, 8'h00},
            {10'h155, OP_DECRYPT, 8'h7E, 1'b0, 8'h00}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, back to back, key changes only with the pipe empty
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (vec_table[i].key != key_shadow) begin
                wait_idle();
                write_key(vec_table[i].key);
            end
            offer_block(vec_table[i].op, vec_table[i].data, vec_table[i].known,
                        vec_table[i].want);
        end

        // random phases, each after a key write and with its own idling mix
        items_left = RANDOM_ITEMS;
        phase      = 0;
        while (items_left > 0) begin
            wait_idle();   // also the pause until every owed beat is out
            case (phase % 5)
                0:       k = 10'h3FF;
                1:       k = 10'h000;
                default: k = sdes_pkg::t_key'($urandom_range(0, 1023));
            endcase
            write_key(k);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            stall_on   = ($urandom_range(0, 3) != 0);
            n_beats    = $urandom_range(40, 160);
            if (n_beats > items_left)
                n_beats = items_left;

            // one phase backs the pipe up: receiver holds off, sender keeps going
            if (phase == 2) begin
                hold_off_req = 1'b1;
                for (int i = 0; i < HOLD_BEATS; i++)
                    offer_block(1'($urandom_range(0, 1)),
                                sdes_pkg::t_block'($urandom_range(0, 255)), 1'b0, 8'h00);
                items_left -= HOLD_BEATS;
            end

            for (int i = 0; i < n_beats; i++) begin
                offer_block(1'($urandom_range(0, 1)),
                            sdes_pkg::t_block'($urandom_range(0, 255)), 1'b0, 8'h00);
                sender_gap();
            end
            items_left -= n_beats;
            phase++;
        end

        // drain, then give stray beats a chance to show up
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_blocks.size() != 0) @(posedge i_clk);
        stall_on = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sdes_block_cipher.f]
+incdir+hdl
hdl/sdes_pkg.sv
hdl/sdes_keysched.sv
hdl/sdes_ip_stage.sv
hdl/sdes_round_stage.sv
hdl/sdes_block_cipher.sv
hdl/sdes_block_cipher_chk.sv
sim/tb_top.sv
